// ===== src/cit_pkg.sv =====
// Shared constants, register indexes and the search token type of the interpolator.
package cit_pkg;

    // Table geometry
    localparam int MAX_POINTS = 8;
    localparam int CHANNELS   = 2;

    // Field widths
    localparam int FLOW_W    = 32;
    localparam int FAC_W     = 16;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CH_IN_W   = 2;
    localparam int IDX_IN_W  = 3;
    localparam int PROD_W    = FLOW_W + FAC_W;

    // Derived widths
    localparam int CNT_W     = $clog2(MAX_POINTS + 1);
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DIV_CNT_W = $clog2(FAC_W + 1);

    // Codes
    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CH0_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CH1_COUNT = 1'd1;

    localparam logic [CFG_W-1:0] COUNT_RST    = 4'd2;
    localparam logic [FAC_W-1:0] UNITY_FACTOR = 16'd16384;

    // Request token handed from cell to cell along the table
    typedef struct packed {
        logic                     valid;
        logic                     is_write;
        logic [CH_W-1:0]          ch;
        logic [CNT_W-1:0]         pos;
        logic [CNT_W-1:0]         n;
        logic [CNT_W-1:0]         wr_idx;
        logic signed [FLOW_W-1:0] flow;
        logic [FAC_W-1:0]         wr_fac;
        logic signed [FLOW_W-1:0] prev_flow;
        logic [FAC_W-1:0]         prev_fac;
        logic                     lo_clamp;
        logic [FAC_W-1:0]         first_fac;
        logic                     hi_clamp;
        logic [FAC_W-1:0]         last_fac;
        logic                     found;
        logic signed [FLOW_W-1:0] f1;
        logic [FAC_W-1:0]         k1;
        logic signed [FLOW_W-1:0] f2;
        logic [FAC_W-1:0]         k2;
    } t_token;

endpackage

// ===== src/cit_cell.sv =====
// One table cell: holds one breakpoint per channel and advances the request token.
module cit_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cit_pkg::t_token i_tok,
    output cit_pkg::t_token o_tok
);
    import cit_pkg::*;

    logic signed [FLOW_W-1:0] r_flow [CHANNELS];
    logic [FAC_W-1:0]         r_fac  [CHANNELS];
    t_token                   r_tok;
    t_token                   n_tok;
    logic signed [FLOW_W-1:0] p_flow;
    logic [FAC_W-1:0]         p_fac;

    // Look at this cell's point and update the token
    always_comb begin
        p_flow = r_flow[i_tok.ch];
        p_fac  = r_fac[i_tok.ch];
        n_tok  = i_tok;
        n_tok.pos = CNT_W'(i_tok.pos + 1'b1);
        if (i_tok.valid && !i_tok.is_write) begin
            if (i_tok.pos == '0) begin
                n_tok.lo_clamp  = (i_tok.flow <= p_flow);
                n_tok.first_fac = p_fac;
            end
            if (i_tok.pos == CNT_W'(i_tok.n - 1'b1)) begin
                n_tok.hi_clamp = (i_tok.flow >= p_flow);
                n_tok.last_fac = p_fac;
            end
            // Keep the first segment that brackets the flow
            if ((i_tok.pos != '0) && (i_tok.pos < i_tok.n) && !i_tok.found &&
                (i_tok.prev_flow <= i_tok.flow) && (i_tok.flow <= p_flow)) begin
                n_tok.found = 1'b1;
                n_tok.f1    = i_tok.prev_flow;
                n_tok.k1    = i_tok.prev_fac;
                n_tok.f2    = p_flow;
                n_tok.k2    = p_fac;
            end
            n_tok.prev_flow = p_flow;
            n_tok.prev_fac  = p_fac;
        end
    end

    // Store a point when a write request reaches its index
    always_ff @(posedge i_clk) begin
        if (i_tok.valid && i_tok.is_write && (i_tok.pos == i_tok.wr_idx)) begin
            r_flow[i_tok.ch] <= i_tok.flow;
            r_fac[i_tok.ch]  <= i_tok.wr_fac;
        end
    end

    // Hand the token to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== src/cit_div.sv =====
// Segment slope unit: one multiply, then a restoring divide one quotient bit per cycle.
module cit_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cit_pkg::FLOW_W-1:0] i_dx,
    input  logic [cit_pkg::FAC_W-1:0]  i_dk,
    input  logic [cit_pkg::FLOW_W-1:0] i_den,
    output logic                       o_done,
    output logic [cit_pkg::FAC_W-1:0]  o_quot
);
    import cit_pkg::*;

    logic [PROD_W-1:0]    r_prod;
    logic [FLOW_W-1:0]    r_rem;
    logic [FAC_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_load;
    logic                 r_run;
    logic                 r_done;
    logic [FLOW_W:0]      trial;
    logic                 qbit;
    logic [FLOW_W-1:0]    n_rem;
    logic [FAC_W-1:0]     n_quo;

    // One restoring step: bring down a bit, subtract the divisor if it fits
    always_comb begin
        trial = {r_rem, r_quo[FAC_W-1]};
        qbit  = (trial >= {1'b0, i_den});
        if (qbit) begin
            n_rem = FLOW_W'(trial - {1'b0, i_den});
        end else begin
            n_rem = trial[FLOW_W-1:0];
        end
        n_quo = {r_quo[FAC_W-2:0], qbit};
    end

    // Product is below den * 2^FAC_W, so its high half starts below den
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= 1'b0;
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_load <= i_start;
            if (r_load) begin
                r_run <= 1'b1;
            end else if (r_run && (r_cnt == DIV_CNT_W'(1))) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PROD_W'(i_dx) * PROD_W'(i_dk);
        end
        if (r_load) begin
            r_rem <= r_prod[PROD_W-1:FAC_W];
            r_quo <= r_prod[FAC_W-1:0];
            r_cnt <= DIV_CNT_W'(FAC_W);
        end else if (r_run) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= DIV_CNT_W'(r_cnt - 1'b1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== src/calib_table_interpolator.sv =====
// Top level of the calibration table interpolator: request control, cell row and slope unit.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries write and query requests.
//   A write request stores one breakpoint {flow, factor} in a channel's table
//   and gives no result; writes are taken every cycle while the block is idle.
//   A query request returns one result on the output channel
//   (o_out_valid / i_out_stall): the interpolated factor and a fallback flag.
//   The point count registers are written through i_cfg_we / i_cfg_idx /
//   i_cfg_data while no request is in flight.
// Query flow:
//   A query walks the row of MAX_POINTS cells, one cell per cycle. A clamped
//   or fallback query then goes to the output register; an interpolated one
//   adds a multiply and a 16-step serial divide. A query on a channel without
//   a table skips the cell row and answers with the fallback. One query is in
//   flight at a time.
// Reset:
//   Synchronous reset clears the request path and sets both point counts to
//   two. Table contents are undefined until written.
// Stall:
//   A result held by i_out_stall stays in the output register; the block
//   still takes the next request and holds its own result until the register
//   frees.
module calib_table_interpolator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cit_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [cit_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_operation,
    input  logic [cit_pkg::CH_IN_W-1:0]         i_channel,
    input  logic [cit_pkg::IDX_IN_W-1:0]        i_point_index,
    input  logic signed [cit_pkg::FLOW_W-1:0]   i_flow_value,
    input  logic [cit_pkg::FAC_W-1:0]           i_point_factor,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [cit_pkg::FAC_W-1:0]           o_gain_factor,
    output logic                                o_fallback
);
    import cit_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WAIT  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [CFG_W-1:0]  r_cnt [CHANNELS];
    t_token            r_inj;
    t_token            n_inj;
    t_token            w_chain [MAX_POINTS+1];
    t_token            tail;
    logic [FLOW_W-1:0] r_dx;
    logic [FLOW_W-1:0] r_den;
    logic [FAC_W-1:0]  r_dk;
    logic              r_neg;
    logic [FAC_W-1:0]  r_k1;
    logic [FAC_W-1:0]  r_res;
    logic              r_fb;
    logic              r_out_valid;
    logic [FAC_W-1:0]  r_out_fac;
    logic              r_out_fb;
    logic              in_acc;
    logic              ch_ok;
    logic              idx_ok;
    logic              tail_query;
    logic              out_free;
    logic              interp;
    logic [FAC_W-1:0]  dec_fac;
    logic              dec_fb;
    logic              div_done;
    logic [FAC_W-1:0]  div_quot;
    logic [CFG_W-1:0]  sel_cnt;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign ch_ok      = int'(i_channel) < CHANNELS;
    assign idx_ok     = int'(i_point_index) < MAX_POINTS;
    assign tail       = w_chain[MAX_POINTS];
    assign tail_query = tail.valid && !tail.is_write;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Point count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_cnt[c] <= COUNT_RST;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CH0_COUNT: r_cnt[0] <= i_cfg_data;
                REG_CH1_COUNT: r_cnt[1] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Build the request token for the head of the cell row
    always_comb begin
        sel_cnt        = r_cnt[i_channel[CH_W-1:0]];
        n_inj          = '0;
        n_inj.is_write = (i_operation == OP_WRITE);
        n_inj.ch       = i_channel[CH_W-1:0];
        n_inj.wr_idx   = CNT_W'(i_point_index);
        n_inj.flow     = i_flow_value;
        n_inj.wr_fac   = i_point_factor;
        if (int'(sel_cnt) > MAX_POINTS) begin
            n_inj.n = CNT_W'(MAX_POINTS);
        end else begin
            n_inj.n = CNT_W'(sel_cnt);
        end
        if (i_operation == OP_WRITE) begin
            n_inj.valid = in_acc && ch_ok && idx_ok;
        end else begin
            n_inj.valid = in_acc && ch_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inj.valid <= 1'b0;
        end else begin
            r_inj <= n_inj;
        end
    end

    // Row of table cells
    assign w_chain[0] = r_inj;
    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        cit_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_chain[g]),
            .o_tok   (w_chain[g+1])
        );
    end

    // Pick clamp, segment or fallback from the finished token
    always_comb begin
        interp  = 1'b0;
        dec_fac = UNITY_FACTOR;
        dec_fb  = 1'b1;
        if (tail.n == '0) begin
            dec_fb = 1'b1;
        end else if (tail.lo_clamp) begin
            dec_fac = tail.first_fac;
            dec_fb  = 1'b0;
        end else if (tail.hi_clamp) begin
            dec_fac = tail.last_fac;
            dec_fb  = 1'b0;
        end else if (tail.found) begin
            dec_fac = tail.k1;
            dec_fb  = 1'b0;
            interp  = (tail.f1 != tail.f2);
        end
    end

    // Sequence one query at a time
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_operation == OP_QUERY)) begin
                    n_state = ch_ok ? S_WAIT : S_DONE;
                end
            end
            S_WAIT: begin
                if (tail_query) begin
                    n_state = interp ? S_START : S_DONE;
                end
            end
            S_START: n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold segment operands and the result
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && in_acc && !ch_ok) begin
            r_res <= UNITY_FACTOR;
            r_fb  <= 1'b1;
        end
        if ((r_state == S_WAIT) && tail_query) begin
            r_res <= dec_fac;
            r_fb  <= dec_fb;
            r_dx  <= FLOW_W'(tail.flow - tail.f1);
            r_den <= FLOW_W'(tail.f2 - tail.f1);
            r_k1  <= tail.k1;
            r_neg <= (tail.k2 < tail.k1);
            if (tail.k2 < tail.k1) begin
                r_dk <= FAC_W'(tail.k1 - tail.k2);
            end else begin
                r_dk <= FAC_W'(tail.k2 - tail.k1);
            end
        end
        if ((r_state == S_DIV) && div_done) begin
            if (r_neg) begin
                r_res <= FAC_W'(r_k1 - div_quot);
            end else begin
                r_res <= FAC_W'(r_k1 + div_quot);
            end
        end
    end

    cit_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_START),
        .i_dx    (r_dx),
        .i_dk    (r_dk),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_fac <= r_res;
            r_out_fb  <= r_fb;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_gain_factor = r_out_fac;
    assign o_fallback    = r_out_fb;

endmodule

// ===== src/cit_checker.sv =====
// Port-level checks on the interpolator, bound to the top level.
module cit_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_cfg_we,
    input logic [cit_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input logic [cit_pkg::CFG_W-1:0]           i_cfg_data,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                i_operation,
    input logic [cit_pkg::CH_IN_W-1:0]         i_channel,
    input logic [cit_pkg::IDX_IN_W-1:0]        i_point_index,
    input logic signed [cit_pkg::FLOW_W-1:0]   i_flow_value,
    input logic [cit_pkg::FAC_W-1:0]           i_point_factor,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [cit_pkg::FAC_W-1:0]           o_gain_factor,
    input logic                                o_fallback
);
    import cit_pkg::*;

    // Fallback results always carry unity
    a_fallback_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fallback |-> o_gain_factor == UNITY_FACTOR)
        else $error("fallback result without unity factor");

    // Reset drops any pending result
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Reset leaves the block ready for a request
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("request side stalled after reset");

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_gain_factor)
            && $stable(o_fallback))
        else $error("stalled result changed");

endmodule

bind calib_table_interpolator cit_checker u_cit_checker (.*);

// ===== sim/cit_result_checker.sv =====
// Result checker of the calibration table interpolator: watches both channels and compares factors and fallback flags.
module cit_result_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cit_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [cit_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic                                i_operation,
    input  logic [cit_pkg::CH_IN_W-1:0]         i_channel,
    input  logic [cit_pkg::IDX_IN_W-1:0]        i_point_index,
    input  logic signed [cit_pkg::FLOW_W-1:0]   i_flow_value,
    input  logic [cit_pkg::FAC_W-1:0]           i_point_factor,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [cit_pkg::FAC_W-1:0]           i_gain_factor,
    input  logic                                i_fallback,
    output int                                  o_errors,
    output int                                  o_pending
);

    import cit_pkg::*;

    typedef struct packed {
        logic [FAC_W-1:0] factor;
        logic             fallback;
    } t_factor_answer;

    // Shadow copy of the breakpoint tables and the point counts
    logic signed [FLOW_W-1:0] pt_flow     [CHANNELS][MAX_POINTS];
    logic [FAC_W-1:0]         pt_factor   [CHANNELS][MAX_POINTS];
    logic [CFG_W-1:0]         point_count [CHANNELS];
    t_factor_answer           pending_factors [$];

    // Compute the factor a query request must return against the shadow tables
    function automatic t_factor_answer predict_factor(
        input logic [CH_IN_W-1:0]       ch,
        input logic signed [FLOW_W-1:0] flow
    );
        t_factor_answer ans;
        int             n;
        longint         fl;
        longint         f1;
        longint         f2;
        longint         k1;
        longint         k2;
        longint         q;
        bit             done;
        ans.factor   = UNITY_FACTOR;
        ans.fallback = 1'b1;
        done         = 1'b0;
        if (ch >= CHANNELS || point_count[ch] == 0) begin
            return ans;
        end
        n  = (point_count[ch] > MAX_POINTS) ? MAX_POINTS : int'(point_count[ch]);
        fl = longint'(flow);
        if (fl <= longint'(pt_flow[ch][0])) begin
            ans.factor   = pt_factor[ch][0];
            ans.fallback = 1'b0;
        end else if (fl >= longint'(pt_flow[ch][n-1])) begin
            ans.factor   = pt_factor[ch][n-1];
            ans.fallback = 1'b0;
        end else begin
            // First segment that brackets the flow wins
            for (int i = 0; i + 1 < n && !done; i++) begin
                f1 = longint'(pt_flow[ch][i]);
                f2 = longint'(pt_flow[ch][i+1]);
                if (fl >= f1 && fl <= f2) begin
                    done         = 1'b1;
                    k1           = longint'(pt_factor[ch][i]);
                    k2           = longint'(pt_factor[ch][i+1]);
                    ans.fallback = 1'b0;
                    if (f2 == f1) begin
                        ans.factor = FAC_W'(k1);
                    end else begin
                        q          = ((fl - f1) * (k2 - k1)) / (f2 - f1);
                        ans.factor = FAC_W'(k1 + q);
                    end
                end
            end
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin : watch
        t_factor_answer exp_ans;
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                point_count[c] = COUNT_RST;
            end
            pending_factors.delete();
        end else begin
            // Retire the result first: it always belongs to an older query
            if (i_out_valid && !i_out_stall) begin
                if (pending_factors.size() == 0) begin
                    $display("%0t: unexpected result, gain_factor %0d fallback %0b",
                             $time, i_gain_factor, i_fallback);
                    o_errors = o_errors + 1;
                end else begin
                    exp_ans = pending_factors.pop_front();
                    if (i_gain_factor !== exp_ans.factor) begin
                        $display("%0t: gain_factor mismatch, expected %0d, actual %0d",
                                 $time, exp_ans.factor, i_gain_factor);
                        o_errors = o_errors + 1;
                    end
                    if (i_fallback !== exp_ans.fallback) begin
                        $display("%0t: fallback mismatch, expected %0b, actual %0b",
                                 $time, exp_ans.fallback, i_fallback);
                        o_errors = o_errors + 1;
                    end
                end
            end
            // Store written points, queue the answer of each query request
            if (i_in_valid && !i_in_stall) begin
                if (i_operation == OP_WRITE) begin
                    if (i_channel < CHANNELS && i_point_index < MAX_POINTS) begin
                        pt_flow[i_channel][i_point_index]   = i_flow_value;
                        pt_factor[i_channel][i_point_index] = i_point_factor;
                    end
                end else begin
                    pending_factors.push_back(predict_factor(i_channel, i_flow_value));
                end
            end
            // Track point count writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CH0_COUNT: point_count[0] = i_cfg_data;
                    REG_CH1_COUNT: point_count[1] = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = pending_factors.size();
    end

endmodule

// ===== sim/tb_calib_table_interpolator.sv =====
// Testbench top of the calibration table interpolator: clock, reset, request stimulus, verdict.
module tb_calib_table_interpolator;

    import cit_pkg::*;

    localparam int     RANDOM_ITEMS  = 1950;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     TAIL_CYCLES   = 100;
    localparam int     COUNT_MAX     = (1 << CFG_W) - 1;
    localparam longint RUN_LIMIT     = 20_000_000;

    typedef enum int {
        SHAPE_SORTED,
        SHAPE_REPEATS,
        SHAPE_UNSORTED
    } t_table_shape;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_idx;
    logic [CFG_W-1:0]         i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic                     i_operation;
    logic [CH_IN_W-1:0]       i_channel;
    logic [IDX_IN_W-1:0]      i_point_index;
    logic signed [FLOW_W-1:0] i_flow_value;
    logic [FAC_W-1:0]         i_point_factor;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [FAC_W-1:0]         o_gain_factor;
    logic                     o_fallback;

    int                       errors;
    int                       pending;
    bit                       quiet;
    int                       random_items;

    // What the stimulus has written, used only to aim queries at segments
    logic signed [FLOW_W-1:0] tab_flow   [CHANNELS][MAX_POINTS];
    int                       count_copy [CHANNELS];

    calib_table_interpolator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_channel      (i_channel),
        .i_point_index  (i_point_index),
        .i_flow_value   (i_flow_value),
        .i_point_factor (i_point_factor),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_gain_factor  (o_gain_factor),
        .o_fallback     (o_fallback)
    );

    cit_result_checker u_result_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_channel      (i_channel),
        .i_point_index  (i_point_index),
        .i_flow_value   (i_flow_value),
        .i_point_factor (i_point_factor),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_gain_factor  (o_gain_factor),
        .i_fallback     (o_fallback),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Pick an idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Offer one request, hold it until accepted, then idle at random
    task automatic send_request(
        input logic                     op,
        input logic [CH_IN_W-1:0]       ch,
        input logic [IDX_IN_W-1:0]      idx,
        input logic signed [FLOW_W-1:0] flow,
        input logic [FAC_W-1:0]         fac
    );
        int gap;
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_channel      <= ch;
        i_point_index  <= idx;
        i_flow_value   <= flow;
        i_point_factor <= fac;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        if (op == OP_WRITE && ch < CHANNELS) begin
            tab_flow[ch][idx] = flow;
        end
        gap = gap_len();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drop valid, wait for all answers, then let any write in flight finish
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write one point count register while the block is idle
    task automatic write_count(input int ch, input int value);
        settle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= (ch == 0) ? REG_CH0_COUNT : REG_CH1_COUNT;
        i_cfg_data <= CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        count_copy[ch] = value;
    endtask

    function automatic int pick_count();
        case ($urandom_range(0, 9))
            0:       return 1;
            1:       return MAX_POINTS;
            2:       return 0;
            3:       return COUNT_MAX;
            4:       return $urandom_range(MAX_POINTS + 1, COUNT_MAX);
            default: return $urandom_range(2, MAX_POINTS);
        endcase
    endfunction

    // Store a whole table: mostly sorted, sometimes with repeated or disordered flows
    task automatic load_table(input int ch, input t_table_shape shape);
        logic signed [FLOW_W-1:0] pts [MAX_POINTS];
        logic signed [FLOW_W-1:0] tmp;
        logic [FAC_W-1:0]         fac;
        int                       sh;
        int                       j;
        sh = $urandom_range(0, 24);
        for (int i = 0; i < MAX_POINTS; i++) begin
            pts[i] = $signed($urandom) >>> sh;
        end
        if (shape != SHAPE_UNSORTED) begin
            for (int i = 1; i < MAX_POINTS; i++) begin
                tmp = pts[i];
                j   = i - 1;
                while (j >= 0 && pts[j] > tmp) begin
                    pts[j+1] = pts[j];
                    j--;
                end
                pts[j+1] = tmp;
            end
        end
        if (shape == SHAPE_REPEATS) begin
            for (int i = 1; i < MAX_POINTS; i++) begin
                if ($urandom_range(0, 2) == 0) begin
                    pts[i] = pts[i-1];
                end
            end
        end
        for (int i = 0; i < MAX_POINTS; i++) begin
            case ($urandom_range(0, 9))
                0:       fac = '0;
                1:       fac = '1;
                default: fac = FAC_W'($urandom);
            endcase
            send_request(OP_WRITE, CH_IN_W'(ch), IDX_IN_W'(i), pts[i], fac);
        end
    endtask

    // Choose a query flow near the ends, on a breakpoint or inside a segment
    function automatic logic signed [FLOW_W-1:0] aimed_flow(input int ch);
        int     n;
        int     seg;
        longint lo;
        longint hi;
        longint span;
        n = (count_copy[ch] > MAX_POINTS) ? MAX_POINTS : count_copy[ch];
        if (n == 0) begin
            return $urandom;
        end
        case ($urandom_range(0, 9))
            0: return tab_flow[ch][0] - $urandom_range(0, 3);
            1: return tab_flow[ch][n-1] + $urandom_range(0, 3);
            2: return tab_flow[ch][$urandom_range(0, n - 1)];
            default: begin
                if (n < 2) begin
                    return $urandom;
                end
                seg = $urandom_range(0, n - 2);
                lo  = longint'(tab_flow[ch][seg]);
                hi  = longint'(tab_flow[ch][seg+1]);
                if (lo > hi) begin
                    span = lo;
                    lo   = hi;
                    hi   = span;
                end
                span = hi - lo + 1;
                return FLOW_W'(lo + longint'({$urandom, $urandom} % span));
            end
        endcase
    endfunction

    // Result side back-pressure
    initial begin : out_stall_gen
        int len;
        i_out_stall = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            len = gap_len();
            if (len > 0) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (len - 1) @(negedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int           n_items;
        int           r;
        int           ch;
        t_table_shape shape;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_operation    = OP_QUERY;
        i_channel      = '0;
        i_point_index  = '0;
        i_flow_value   = '0;
        i_point_factor = '0;
        quiet          = 1'b0;
        random_items   = 0;
        for (int c = 0; c < CHANNELS; c++) begin
            count_copy[c] = int'(COUNT_RST);
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Fill both tables completely so every later query reads written entries
        send_request(OP_WRITE, 2'd0, 3'd0, -(100 <<< 16), 16'd0);
        send_request(OP_WRITE, 2'd0, 3'd1, -(50 <<< 16), 16'd65535);
        send_request(OP_WRITE, 2'd0, 3'd2, -(50 <<< 16), 16'd20000);
        send_request(OP_WRITE, 2'd0, 3'd3, 0, 16'd16384);
        send_request(OP_WRITE, 2'd0, 3'd4, 10 <<< 16, 16'd16383);
        send_request(OP_WRITE, 2'd0, 3'd5, 300 <<< 16, 16'd1);
        send_request(OP_WRITE, 2'd0, 3'd6, 301 <<< 16, 16'd40000);
        send_request(OP_WRITE, 2'd0, 3'd7, 1000 <<< 16, 16'd12345);
        send_request(OP_WRITE, 2'd1, 3'd0, 32'sh8000_0000, 16'd16384);
        send_request(OP_WRITE, 2'd1, 3'd1, -1000000, 16'd100);
        send_request(OP_WRITE, 2'd1, 3'd2, -1, 16'd65535);
        send_request(OP_WRITE, 2'd1, 3'd3, 0, 16'd0);
        send_request(OP_WRITE, 2'd1, 3'd4, 0, 16'd9999);
        send_request(OP_WRITE, 2'd1, 3'd5, 500000, 16'd30000);
        send_request(OP_WRITE, 2'd1, 3'd6, 1000000000, 16'd65535);
        send_request(OP_WRITE, 2'd1, 3'd7, 32'sh7FFF_FFFF, 16'd7);

        // Clamp below and above, exact first point, a rising segment, clamp above on channel 1
        send_request(OP_QUERY, 2'd0, 3'd0, 32'sh8000_0000, 16'd0);
        send_request(OP_QUERY, 2'd0, 3'd7, 32'sh7FFF_FFFF, 16'hFFFF);
        send_request(OP_QUERY, 2'd0, 3'd3, -(75 <<< 16), 16'd0);
        send_request(OP_QUERY, 2'd0, 3'd0, -(100 <<< 16), 16'd0);
        send_request(OP_QUERY, 2'd1, 3'd0, -500000, 16'd0);
        // Channels without a table: query falls back, write is dropped
        send_request(OP_QUERY, 2'd2, 3'd0, 0, 16'd0);
        send_request(OP_QUERY, 2'd3, 3'd7, 32'sh7FFF_FFFF, 16'hFFFF);
        send_request(OP_WRITE, 2'd2, 3'd0, 32'sh7FFF_FFFF, 16'hFFFF);
        send_request(OP_WRITE, 2'd3, 3'd7, 32'sh8000_0000, 16'd0);
        // Full table on channel 0: repeated flows, narrow segments
        write_count(0, MAX_POINTS);
        send_request(OP_QUERY, 2'd0, 3'd0, -(50 <<< 16), 16'd0);
        send_request(OP_QUERY, 2'd0, 3'd0, 5 <<< 16, 16'd0);
        send_request(OP_QUERY, 2'd0, 3'd0, (300 <<< 16) + 1, 16'd0);
        // Count above the table size saturates
        write_count(1, COUNT_MAX);
        send_request(OP_QUERY, 2'd1, 3'd0, 32'sh7FFF_FFFF, 16'd0);
        send_request(OP_QUERY, 2'd1, 3'd0, 0, 16'd0);
        // Empty table falls back, single point returns its factor everywhere
        write_count(0, 0);
        send_request(OP_QUERY, 2'd0, 3'd0, 0, 16'd0);
        write_count(1, 1);
        send_request(OP_QUERY, 2'd1, 3'd0, 12345, 16'd0);

        // Random phases: new counts, often new tables, then a burst of requests
        while (random_items < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 4) == 0);
            write_count(0, pick_count());
            write_count(1, pick_count());
            for (int c = 0; c < CHANNELS; c++) begin
                if ($urandom_range(0, 1) == 1) begin
                    r = $urandom_range(0, 9);
                    if (r < 7) begin
                        shape = SHAPE_SORTED;
                    end else if (r < 9) begin
                        shape = SHAPE_REPEATS;
                    end else begin
                        shape = SHAPE_UNSORTED;
                    end
                    load_table(c, shape);
                    random_items += MAX_POINTS;
                end
            end
            n_items = $urandom_range(20, 60);
            repeat (n_items) begin
                r  = $urandom_range(0, 99);
                ch = $urandom_range(0, CHANNELS - 1);
                if (r < 70) begin
                    send_request(OP_QUERY, CH_IN_W'(ch), IDX_IN_W'($urandom),
                                 aimed_flow(ch), FAC_W'($urandom));
                end else if (r < 82) begin
                    ch = $urandom_range(0, 3);
                    send_request(OP_QUERY, CH_IN_W'(ch), IDX_IN_W'($urandom),
                                 $urandom, FAC_W'($urandom));
                end else begin
                    // Stray point writes, some on channels without a table
                    ch = $urandom_range(0, 3);
                    send_request(OP_WRITE, CH_IN_W'(ch), IDX_IN_W'($urandom),
                                 $urandom, FAC_W'($urandom));
                end
                random_items++;
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
